[rtl/pdtc_pkg.sv]
package pdtc_pkg;

    // Fixed field widths and the fixed-point format of the gains.
    localparam int POSITION_BITS  = 16;
    localparam int TARGET_BITS    = 16;
    localparam int GAIN_BITS      = 32;
    localparam int GAIN_FRAC_BITS = 24;
    localparam int SUM_BITS       = 32;
    localparam int POWER_BITS     = 7;
    localparam int LIMIT_BITS     = 31;
    localparam int DRIVE_BITS     = POWER_BITS + 1;

    // Error and derivative widths: the error carries two bits more than a position, the derivative one more.
    localparam int ERR_BITS   = POSITION_BITS + 2;
    localparam int DERIV_BITS = ERR_BITS + 1;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    // Register values after reset.
    localparam logic [GAIN_BITS-1:0]         KP_RESET        = 32'd1342177;
    localparam logic [GAIN_BITS-1:0]         KI_RESET        = 32'd13;
    localparam logic [GAIN_BITS-1:0]         KD_RESET        = 32'd0;
    localparam logic [GAIN_BITS-1:0]         KC_RESET        = 32'd52009369;
    localparam logic [POWER_BITS-1:0]        MAX_POWER_RESET = 7'd127;
    localparam logic [LIMIT_BITS-1:0]        SUM_LIMIT_RESET = 31'd62500000;
    localparam logic signed [TARGET_BITS-1:0] TARGET_RESET   = 16'sd0;

    // Operating modes.
    typedef enum logic [1:0] {
        MODE_DRIVE      = 2'd0,
        MODE_TURN_LEFT  = 2'd1,
        MODE_TURN_RIGHT = 2'd2,
        MODE_HOLD       = 2'd3
    } mode_t;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MODE      = 3'd0,
        REG_TARGET    = 3'd1,
        REG_KP        = 3'd2,
        REG_KI        = 3'd3,
        REG_KD        = 3'd4,
        REG_KC        = 3'd5,
        REG_MAX_POWER = 3'd6,
        REG_SUM_LIMIT = 3'd7
    } cfg_reg_t;

    // One sensor sample.
    typedef struct packed {
        logic                            restart;
        logic signed [POSITION_BITS-1:0] main_position;
        logic signed [POSITION_BITS-1:0] side_position;
    } sample_t;

    // One motor command.
    typedef struct packed {
        logic signed [DRIVE_BITS-1:0] left_drive;
        logic signed [DRIVE_BITS-1:0] right_drive;
        logic                         at_target;
    } drive_t;

    // Current register settings.
    typedef struct packed {
        mode_t                         mode;
        logic signed [TARGET_BITS-1:0] target;
        logic [GAIN_BITS-1:0]          kp;
        logic [GAIN_BITS-1:0]          ki;
        logic [GAIN_BITS-1:0]          kd;
        logic [GAIN_BITS-1:0]          kc;
        logic [POWER_BITS-1:0]         max_power;
        logic [LIMIT_BITS-1:0]         sum_limit;
    } cfg_t;

    // Error terms of one sample, ready for the gain multipliers.
    typedef struct packed {
        mode_t                        mode;
        logic                         done;
        logic signed [ERR_BITS-1:0]   err;
        logic signed [SUM_BITS-1:0]   sum;
        logic signed [DERIV_BITS-1:0] deriv;
        logic signed [ERR_BITS-1:0]   drift;
    } err_t;

endpackage

[rtl/pdtc_error_update.sv]
module pdtc_error_update
    import pdtc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  sample_t sample,
    input  logic    advance,
    output err_t    result
);

    localparam int ZONE_BITS = ERR_BITS + 3;

    logic signed [SUM_BITS-1:0]  error_sum_reg, error_sum_next;
    logic signed [ERR_BITS-1:0]  previous_error_reg, previous_error_next;

    logic signed [SUM_BITS-1:0]  sum_base;
    logic signed [ERR_BITS-1:0]  prev_base;
    logic signed [ERR_BITS-1:0]  main_ext, side_ext, target_ext, main_mag;
    logic signed [ERR_BITS-1:0]  err_drive, err_turn, err_drive_mag, err_sel;
    logic signed [ZONE_BITS-1:0] zone_drive, zone_turn, zone_target;
    logic signed [SUM_BITS:0]    sum_add, limit_ext;
    logic signed [SUM_BITS-1:0]  sum_sat, sum_pick;
    logic                        is_drive;

    // A restart clears the state before this sample is used.
    assign sum_base  = sample.restart ? '0 : error_sum_reg;
    assign prev_base = sample.restart ? '0 : previous_error_reg;

    // Errors for both mode families.
    assign main_ext      = ERR_BITS'(sample.main_position);
    assign side_ext      = ERR_BITS'(sample.side_position);
    assign target_ext    = ERR_BITS'(cfg.target);
    assign main_mag      = main_ext[ERR_BITS-1] ? -main_ext : main_ext;
    assign err_drive     = target_ext - main_ext;
    assign err_turn      = target_ext - main_mag;
    assign err_drive_mag = err_drive[ERR_BITS-1] ? -err_drive : err_drive;
    assign is_drive      = (cfg.mode == MODE_DRIVE);
    assign err_sel       = is_drive ? err_drive : err_turn;

    // Integral zone compares eight times the error against the target.
    assign zone_drive  = ZONE_BITS'(err_drive_mag) <<< 3;
    assign zone_turn   = ZONE_BITS'(err_turn) <<< 3;
    assign zone_target = ZONE_BITS'(cfg.target);

    // Accumulate with saturation to the signed range of the accumulator.
    assign sum_add = (SUM_BITS + 1)'(sum_base) + (SUM_BITS + 1)'(err_sel);
    always_comb
    begin
        if (sum_add[SUM_BITS] != sum_add[SUM_BITS-1])
        begin
            sum_sat = {sum_add[SUM_BITS], {(SUM_BITS - 1){~sum_add[SUM_BITS]}}};
        end
        else
        begin
            sum_sat = sum_add[SUM_BITS-1:0];
        end
    end

    // Zone decision per mode family.
    always_comb
    begin
        if (is_drive)
        begin
            sum_pick = (zone_drive < zone_target) ? sum_sat : '0;
        end
        else if (zone_turn < zone_target)
        begin
            sum_pick = sum_sat;
        end
        else if (zone_turn > zone_target)
        begin
            sum_pick = '0;
        end
        else
        begin
            sum_pick = sum_base;
        end
    end

    // Upper clamp, then the next state. The unused mode leaves the state alone, apart from a restart.
    assign limit_ext = $signed((SUM_BITS + 1)'(cfg.sum_limit));
    always_comb
    begin
        if (cfg.mode == MODE_HOLD)
        begin
            error_sum_next      = sum_base;
            previous_error_next = prev_base;
        end
        else
        begin
            if ((SUM_BITS + 1)'(sum_pick) > limit_ext)
            begin
                error_sum_next = limit_ext[SUM_BITS-1:0];
            end
            else
            begin
                error_sum_next = sum_pick;
            end
            previous_error_next = err_sel;
        end
    end

    // Terms handed on to the multiplier stage.
    always_comb
    begin
        result.mode  = cfg.mode;
        result.done  = (err_sel == '0);
        result.err   = err_sel;
        result.sum   = error_sum_next;
        result.deriv = DERIV_BITS'(err_sel) - DERIV_BITS'(prev_base);
        result.drift = main_ext - side_ext;
    end

    // Controller state advances once per sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg      <= '0;
            previous_error_reg <= '0;
        end
        else if (advance)
        begin
            error_sum_reg      <= error_sum_next;
            previous_error_reg <= previous_error_next;
        end
    end

endmodule

[rtl/pid_drive_turn_controller.sv]
// PID drive and turn controller: takes one encoder or gyro sample per transaction and returns
// one left/right motor command. A new sample can be accepted every cycle in which sample_stall
// is low; each result passes through a five-register pipeline (sample register, error and
// accumulator update, gain multipliers, power sum and saturation, side correction and result
// register). The accumulator and previous error are updated when a sample leaves the sample
// register, so samples are processed strictly in order. Registers are written through the cfg
// port, which is always ready; write them only while no transaction is in flight.
module pid_drive_turn_controller
    import pdtc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_stall,
    input  sample_t                   sample,
    output logic                      drive_valid,
    input  logic                      drive_stall,
    output drive_t                    drive,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int KP_PROD_BITS = GAIN_BITS + 1 + ERR_BITS;
    localparam int KI_PROD_BITS = GAIN_BITS + 1 + SUM_BITS;
    localparam int KD_PROD_BITS = GAIN_BITS + 1 + DERIV_BITS;
    localparam int KC_PROD_BITS = GAIN_BITS + 1 + ERR_BITS;
    localparam int TOTAL_BITS   = KI_PROD_BITS + 2;
    localparam int PQ_BITS      = GAIN_FRAC_BITS + POWER_BITS + 1;
    localparam int SIDE_BITS    = KC_PROD_BITS + 1;
    localparam int WHOLE_BITS   = SIDE_BITS - GAIN_FRAC_BITS;

    // Truncate a Q.F value toward zero.
    function automatic logic signed [WHOLE_BITS-1:0] trunc_q(
        input logic signed [SIDE_BITS-1:0] v
    );
        logic signed [WHOLE_BITS-1:0] floor_v;
        floor_v = WHOLE_BITS'(v >>> GAIN_FRAC_BITS);
        if (v[SIDE_BITS-1] && (v[GAIN_FRAC_BITS-1:0] != '0))
        begin
            floor_v = floor_v + WHOLE_BITS'(1);
        end
        return floor_v;
    endfunction

    // Saturate a whole-number power to the symmetric limit.
    function automatic logic signed [DRIVE_BITS-1:0] sat_drive(
        input logic signed [WHOLE_BITS-1:0] v,
        input logic [POWER_BITS-1:0]        limit
    );
        logic signed [WHOLE_BITS-1:0] lim_w;
        logic signed [DRIVE_BITS-1:0] res;
        lim_w = $signed(WHOLE_BITS'(limit));
        if (v > lim_w)
        begin
            res = $signed(DRIVE_BITS'(limit));
        end
        else if (v < -lim_w)
        begin
            res = -$signed(DRIVE_BITS'(limit));
        end
        else
        begin
            res = v[DRIVE_BITS-1:0];
        end
        return res;
    endfunction

    cfg_t cfg_reg;

    logic    sample_valid_reg;
    sample_t sample_reg;

    logic  err_valid_reg;
    err_t  err_reg;
    err_t  err_result;

    logic                           prod_valid_reg;
    logic signed [KP_PROD_BITS-1:0] kp_prod_reg;
    logic signed [KI_PROD_BITS-1:0] ki_prod_reg;
    logic signed [KD_PROD_BITS-1:0] kd_prod_reg;
    logic signed [KC_PROD_BITS-1:0] kc_prod_reg;
    mode_t                          prod_mode_reg;
    logic                           prod_done_reg;

    logic                           power_valid_reg;
    logic signed [PQ_BITS-1:0]      pq_reg, pq_next;
    logic signed [KC_PROD_BITS-1:0] dq_reg;
    mode_t                          power_mode_reg;
    logic                           power_done_reg;

    logic   drive_valid_reg;
    drive_t drive_reg, drive_next;

    logic sample_ready, err_ready, prod_ready, power_ready, drive_ready;

    logic signed [GAIN_BITS:0]     kp_s, ki_s, kd_s, kc_s;
    logic signed [TOTAL_BITS-1:0]  total, power_lim;
    logic signed [SIDE_BITS-1:0]   pq_ext, dq_ext;
    logic signed [DRIVE_BITS-1:0]  right_sat, left_sat, turn_sat;

    // Configuration registers.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= MODE_DRIVE;
            cfg_reg.target    <= TARGET_RESET;
            cfg_reg.kp        <= KP_RESET;
            cfg_reg.ki        <= KI_RESET;
            cfg_reg.kd        <= KD_RESET;
            cfg_reg.kc        <= KC_RESET;
            cfg_reg.max_power <= MAX_POWER_RESET;
            cfg_reg.sum_limit <= SUM_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE:      cfg_reg.mode      <= mode_t'(cfg_data[1:0]);
                REG_TARGET:    cfg_reg.target    <= $signed(cfg_data[TARGET_BITS-1:0]);
                REG_KP:        cfg_reg.kp        <= cfg_data[GAIN_BITS-1:0];
                REG_KI:        cfg_reg.ki        <= cfg_data[GAIN_BITS-1:0];
                REG_KD:        cfg_reg.kd        <= cfg_data[GAIN_BITS-1:0];
                REG_KC:        cfg_reg.kc        <= cfg_data[GAIN_BITS-1:0];
                REG_MAX_POWER: cfg_reg.max_power <= cfg_data[POWER_BITS-1:0];
                REG_SUM_LIMIT: cfg_reg.sum_limit <= cfg_data[LIMIT_BITS-1:0];
                default:       cfg_reg.mode      <= cfg_reg.mode;
            endcase
        end
    end

    // Each stage takes new data when it is empty or its content moves on.
    assign drive_ready  = !drive_valid_reg || !drive_stall;
    assign power_ready  = !power_valid_reg || drive_ready;
    assign prod_ready   = !prod_valid_reg || power_ready;
    assign err_ready    = !err_valid_reg || prod_ready;
    assign sample_ready = !sample_valid_reg || err_ready;
    assign sample_stall = !sample_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
            err_valid_reg    <= 1'b0;
            prod_valid_reg   <= 1'b0;
            power_valid_reg  <= 1'b0;
            drive_valid_reg  <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                sample_valid_reg <= sample_valid;
            end
            if (err_ready)
            begin
                err_valid_reg <= sample_valid_reg;
            end
            if (prod_ready)
            begin
                prod_valid_reg <= err_valid_reg;
            end
            if (power_ready)
            begin
                power_valid_reg <= prod_valid_reg;
            end
            if (drive_ready)
            begin
                drive_valid_reg <= power_valid_reg;
            end
        end
    end

    // Error terms and controller state.
    pdtc_error_update u_error_update (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .sample  (sample_reg),
        .advance (sample_valid_reg && err_ready),
        .result  (err_result)
    );

    // Gains as non-negative signed operands.
    assign kp_s = $signed({1'b0, cfg_reg.kp});
    assign ki_s = $signed({1'b0, cfg_reg.ki});
    assign kd_s = $signed({1'b0, cfg_reg.kd});
    assign kc_s = $signed({1'b0, cfg_reg.kc});

    // Sum of the three control terms, saturated to the power limit in Q.F.
    assign total = TOTAL_BITS'(kp_prod_reg) + TOTAL_BITS'(ki_prod_reg)
                 + TOTAL_BITS'(kd_prod_reg);
    assign power_lim = $signed(TOTAL_BITS'({cfg_reg.max_power, {GAIN_FRAC_BITS{1'b0}}}));
    always_comb
    begin
        if (total > power_lim)
        begin
            pq_next = power_lim[PQ_BITS-1:0];
        end
        else if (total < -power_lim)
        begin
            pq_next = PQ_BITS'(-power_lim);
        end
        else
        begin
            pq_next = total[PQ_BITS-1:0];
        end
    end

    // Side powers: drift correction in drive mode, opposite signs when turning, zero in hold mode.
    assign pq_ext    = SIDE_BITS'(pq_reg);
    assign dq_ext    = SIDE_BITS'(dq_reg);
    assign right_sat = sat_drive(trunc_q(pq_ext - dq_ext), cfg_reg.max_power);
    assign left_sat  = sat_drive(trunc_q(pq_ext + dq_ext), cfg_reg.max_power);
    assign turn_sat  = sat_drive(trunc_q(pq_ext), cfg_reg.max_power);

    always_comb
    begin
        drive_next.at_target = power_done_reg;
        case (power_mode_reg)
            MODE_DRIVE:
            begin
                drive_next.left_drive  = left_sat;
                drive_next.right_drive = right_sat;
            end
            MODE_TURN_LEFT:
            begin
                drive_next.left_drive  = -turn_sat;
                drive_next.right_drive = turn_sat;
            end
            MODE_TURN_RIGHT:
            begin
                drive_next.left_drive  = turn_sat;
                drive_next.right_drive = -turn_sat;
            end
            default:
            begin
                drive_next.left_drive  = '0;
                drive_next.right_drive = '0;
                drive_next.at_target   = 1'b0;
            end
        endcase
    end

    // Pipeline data registers.
    always_ff @(posedge clk)
    begin
        if (sample_ready)
        begin
            sample_reg <= sample;
        end
        if (err_ready)
        begin
            err_reg <= err_result;
        end
        if (prod_ready)
        begin
            kp_prod_reg   <= kp_s * $signed(err_reg.err);
            ki_prod_reg   <= ki_s * $signed(err_reg.sum);
            kd_prod_reg   <= kd_s * $signed(err_reg.deriv);
            kc_prod_reg   <= kc_s * $signed(err_reg.drift);
            prod_mode_reg <= err_reg.mode;
            prod_done_reg <= err_reg.done;
        end
        if (power_ready)
        begin
            pq_reg         <= pq_next;
            dq_reg         <= kc_prod_reg;
            power_mode_reg <= prod_mode_reg;
            power_done_reg <= prod_done_reg;
        end
        if (drive_ready)
        begin
            drive_reg <= drive_next;
        end
    end

    assign drive_valid = drive_valid_reg;
    assign drive       = drive_reg;

endmodule

[sim/tb_pid_drive_turn_controller.sv]
`timescale 1ns / 100ps

module tb_pid_drive_turn_controller;
    import pdtc_pkg::*;

    localparam int          SETTLE_CYCLES = 8;
    localparam int unsigned RUN_LIMIT_NS  = 10_000_000;
    localparam int          RANDOM_ITEMS  = 1700;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      sample_valid = 1'b0;
    logic                      sample_stall;
    sample_t                   sample = '0;
    logic                      drive_valid;
    logic                      drive_stall = 1'b0;
    drive_t                    drive;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // Expected motor commands, oldest first.
    drive_t expected_drives[$];

    // Controller state as the checker tracks it.
    cfg_t   shadow_cfg;
    longint acc_error;
    longint prev_error;

    int error_count     = 0;
    int samples_sent    = 0;
    int drives_checked  = 0;
    int settings_loaded = 0;

    // Idling controls shared by the test tasks and the two sides.
    bit send_gaps_on   = 1'b1;
    bit recv_stalls_on = 1'b1;
    int hold_request   = 0;

    pid_drive_turn_controller uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .drive_valid  (drive_valid),
        .drive_stall  (drive_stall),
        .drive        (drive),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Fails the run if it hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // Control law prediction
    // ---------------------------------------------------------------

    // Adds sign(x) * g * |x| as hi * 2^F + lo.
    function automatic void add_gain_term(input longint g, input longint x,
                                          inout longint hi, inout longint lo);
        longint m;
        longint a;
        longint b;
        longint mask;
        mask = (64'sd1 <<< GAIN_FRAC_BITS) - 1;
        m = (x < 0) ? -x : x;
        a = g * (m >>> GAIN_FRAC_BITS);
        b = g * (m & mask);
        if (x < 0)
        begin
            hi -= a;
            lo -= b;
        end
        else
        begin
            hi += a;
            lo += b;
        end
    endfunction

    // Joins the two parts; an oversized high part only keeps its sign.
    function automatic longint merge_parts(input longint hi, input longint lo);
        longint cap;
        cap = 64'sd1 <<< 36;
        if (hi > cap)
            hi = cap;
        if (hi < -cap)
            hi = -cap;
        return hi * (64'sd1 <<< GAIN_FRAC_BITS) + lo;
    endfunction

    function automatic longint trunc_frac(input longint v);
        return (v >= 0) ? (v >>> GAIN_FRAC_BITS) : -((-v) >>> GAIN_FRAC_BITS);
    endfunction

    function automatic longint clip(input longint v, input longint lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    // Works out the motor command for one sample and advances the tracked state.
    function automatic drive_t compute_drive(input sample_t s);
        longint mainp;
        longint side;
        longint tgt;
        longint err;
        longint mag;
        longint deriv;
        longint hi;
        longint lo;
        longint dh;
        longint dl;
        longint pq;
        longint dq;
        longint lim;
        longint maxp;
        longint left;
        longint right;
        longint p;
        longint smax;
        longint smin;
        logic   done;
        drive_t r;
        mainp = s.main_position;
        side  = s.side_position;
        tgt   = shadow_cfg.target;
        maxp  = longint'(shadow_cfg.max_power);
        smax  = (64'sd1 <<< (SUM_BITS - 1)) - 1;
        smin  = -smax - 1;
        hi = 0;
        lo = 0;
        r  = '0;
        if (s.restart)
        begin
            acc_error  = 0;
            prev_error = 0;
        end
        if (shadow_cfg.mode == MODE_HOLD)
            return r;

        // Error and integral zone.
        if (shadow_cfg.mode == MODE_DRIVE)
        begin
            err  = tgt - mainp;
            mag  = (err < 0) ? -err : err;
            done = (mainp == tgt);
            if (8 * mag < tgt)
                acc_error += err;
            else
                acc_error = 0;
        end
        else
        begin
            mag  = (mainp < 0) ? -mainp : mainp;
            err  = tgt - mag;
            done = (mag == tgt);
            if (8 * err < tgt)
                acc_error += err;
            else if (8 * err > tgt)
                acc_error = 0;
        end
        if (acc_error > smax)
            acc_error = smax;
        if (acc_error < smin)
            acc_error = smin;
        if (acc_error > longint'(shadow_cfg.sum_limit))
            acc_error = longint'(shadow_cfg.sum_limit);

        deriv      = err - prev_error;
        prev_error = err;

        // Sum of the three gain products, saturated in fixed point.
        add_gain_term(longint'(shadow_cfg.kp), err, hi, lo);
        add_gain_term(longint'(shadow_cfg.ki), acc_error, hi, lo);
        add_gain_term(longint'(shadow_cfg.kd), deriv, hi, lo);
        lim = maxp <<< GAIN_FRAC_BITS;
        pq  = clip(merge_parts(hi, lo), lim);

        if (shadow_cfg.mode == MODE_DRIVE)
        begin
            dh = 0;
            dl = 0;
            add_gain_term(longint'(shadow_cfg.kc), mainp - side, dh, dl);
            dq    = merge_parts(dh, dl);
            right = clip(trunc_frac(pq - dq), maxp);
            left  = clip(trunc_frac(pq + dq), maxp);
        end
        else
        begin
            p = trunc_frac(pq);
            if (shadow_cfg.mode == MODE_TURN_LEFT)
            begin
                left  = -p;
                right = p;
            end
            else
            begin
                left  = p;
                right = -p;
            end
        end
        r.left_drive  = left[DRIVE_BITS-1:0];
        r.right_drive = right[DRIVE_BITS-1:0];
        r.at_target   = done;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic int sample_gap();
        int pick;
        if (!send_gaps_on)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int stall_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int clamp16(input int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic sample_t make_sample(input bit restart, input int mainp, input int side);
        sample_t s;
        s.restart       = restart;
        s.main_position = 16'(mainp);
        s.side_position = 16'(side);
        return s;
    endfunction

    function automatic cfg_t make_settings(input mode_t m, input int tgt,
                                           input logic [31:0] kp, input logic [31:0] ki,
                                           input logic [31:0] kd, input logic [31:0] kc,
                                           input int maxp, input logic [30:0] suml);
        cfg_t c;
        c.mode      = m;
        c.target    = 16'(tgt);
        c.kp        = kp;
        c.ki        = ki;
        c.kd        = kd;
        c.kc        = kc;
        c.max_power = 7'(maxp);
        c.sum_limit = suml;
        return c;
    endfunction

    // Offers one sample after a random gap and records its expected command on acceptance.
    task automatic send_sample(input sample_t s);
        int gap;
        gap = sample_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        do
            @(posedge clk);
        while (sample_stall);
        expected_drives.push_back(compute_drive(s));
        samples_sent++;
    endtask

    // Stops offering samples and waits until every command has come back.
    task automatic drain_pipeline();
        sample_valid <= 1'b0;
        while (expected_drives.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MODE:      shadow_cfg.mode      = mode_t'(value[1:0]);
            REG_TARGET:    shadow_cfg.target    = value[TARGET_BITS-1:0];
            REG_KP:        shadow_cfg.kp        = value;
            REG_KI:        shadow_cfg.ki        = value;
            REG_KD:        shadow_cfg.kd        = value;
            REG_KC:        shadow_cfg.kc        = value;
            REG_MAX_POWER: shadow_cfg.max_power = value[POWER_BITS-1:0];
            REG_SUM_LIMIT: shadow_cfg.sum_limit = value[LIMIT_BITS-1:0];
            default:       ;
        endcase
    endtask

    // Writes every register while the controller is idle.
    task automatic load_settings(input cfg_t c);
        drain_pipeline();
        write_reg(REG_MODE, 32'(c.mode));
        write_reg(REG_TARGET, 32'(c.target));
        write_reg(REG_KP, c.kp);
        write_reg(REG_KI, c.ki);
        write_reg(REG_KD, c.kd);
        write_reg(REG_KC, c.kc);
        write_reg(REG_MAX_POWER, 32'(c.max_power));
        write_reg(REG_SUM_LIMIT, 32'(c.sum_limit));
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    function automatic logic [31:0] random_gain();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom();
            default: return $urandom_range(0, 32'h0400_0000) >> $urandom_range(0, 16);
        endcase
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        int   pick;
        pick = $urandom_range(0, 9);
        c.mode = (pick < 4) ? MODE_DRIVE : (pick < 6) ? MODE_TURN_LEFT :
                 (pick < 9) ? MODE_TURN_RIGHT : MODE_HOLD;
        case ($urandom_range(0, 6))
            0:       c.target = 16'sh7FFF;
            1:       c.target = 16'sh8000;
            2:       c.target = 16'($urandom());
            default: c.target = 16'($urandom_range(0, 4000) - 1000);
        endcase
        c.kp = random_gain();
        c.ki = random_gain();
        c.kd = random_gain();
        c.kc = random_gain();
        case ($urandom_range(0, 5))
            0:       c.max_power = 7'd0;
            1:       c.max_power = 7'd127;
            default: c.max_power = 7'($urandom_range(0, 127));
        endcase
        case ($urandom_range(0, 5))
            0:       c.sum_limit = 31'd0;
            1:       c.sum_limit = 31'h7FFF_FFFF;
            2:       c.sum_limit = 31'($urandom());
            default: c.sum_limit = 31'($urandom_range(0, 100000));
        endcase
        return c;
    endfunction

    // ---------------------------------------------------------------
    // Result checking and output stalls
    // ---------------------------------------------------------------

    task automatic check_drive(input drive_t got);
        drive_t want;
        if (expected_drives.size() == 0)
        begin
            report_mismatch($sformatf("unexpected transaction left=%0d right=%0d at_target=%0b",
                                      got.left_drive, got.right_drive, got.at_target));
            return;
        end
        want = expected_drives.pop_front();
        drives_checked++;
        if (got.left_drive !== want.left_drive)
            report_mismatch($sformatf("command %0d left_drive expected %0d got %0d",
                                      drives_checked, want.left_drive, got.left_drive));
        if (got.right_drive !== want.right_drive)
            report_mismatch($sformatf("command %0d right_drive expected %0d got %0d",
                                      drives_checked, want.right_drive, got.right_drive));
        if (got.at_target !== want.at_target)
            report_mismatch($sformatf("command %0d at_target expected %0b got %0b",
                                      drives_checked, want.at_target, got.at_target));
    endtask

    // Accepts commands and stalls the output at random or for a requested hold-off.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && drive_valid && !drive_stall)
                check_drive(drive);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0 && recv_stalls_on && $urandom_range(0, 99) < 20)
                stall_left = stall_length();
            if (stall_left > 0)
            begin
                drive_stall <= 1'b1;
                stall_left--;
            end
            else
                drive_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Register values after reset with the position extremes.
    task automatic test_reset_values();
        send_sample(make_sample(1'b0, 32767, -32768));
        send_sample(make_sample(1'b0, -32768, 32767));
        send_sample(make_sample(1'b1, 0, 0));
    endtask

    // Drive mode: integral zone, target reached, out of zone, restart, negative target.
    task automatic test_drive_mode();
        load_settings(make_settings(MODE_DRIVE, 800, 32'hFFFF_FFFF, 32'h0100_0000,
                                    32'h0080_0000, 32'd0, 127, 31'd62500000));
        send_sample(make_sample(1'b0, 750, 740));
        send_sample(make_sample(1'b0, 700, 720));
        send_sample(make_sample(1'b0, 800, 800));
        send_sample(make_sample(1'b0, 100, 90));
        send_sample(make_sample(1'b1, 790, 780));
        // An empty integral zone, zero power limit and the largest drift gain.
        load_settings(make_settings(MODE_DRIVE, -500, 32'h0100_0000, 32'h0100_0000,
                                    32'd0, 32'hFFFF_FFFF, 0, 31'd0));
        send_sample(make_sample(1'b0, -500, 200));
        send_sample(make_sample(1'b0, -400, -32768));
    endtask

    // Turn modes: opposite signs, zone boundary, upper clamp of the sum, gyro extremes.
    task automatic test_turn_modes();
        load_settings(make_settings(MODE_TURN_LEFT, 800, 32'h0100_0000, 32'h0010_0000,
                                    32'h0040_0000, 32'd0, 100, 31'd0));
        send_sample(make_sample(1'b1, -700, 0));
        send_sample(make_sample(1'b0, 750, 0));
        send_sample(make_sample(1'b0, -900, 0));
        send_sample(make_sample(1'b0, 800, 0));
        send_sample(make_sample(1'b0, -32768, 0));
        load_settings(make_settings(MODE_TURN_RIGHT, 32767, 32'h0002_0000, 32'd13,
                                    32'h0001_0000, 32'd52009369, 127, 31'h7FFF_FFFF));
        send_sample(make_sample(1'b0, 0, 0));
        send_sample(make_sample(1'b0, 32767, 5));
        send_sample(make_sample(1'b1, -32768, 0));
    endtask

    // The unused mode gives zero commands and keeps the state apart from a restart.
    task automatic test_hold_mode();
        load_settings(make_settings(MODE_DRIVE, 1000, 32'h0020_0000, 32'h0008_0000,
                                    32'h0010_0000, 32'h0004_0000, 90, 31'd50000));
        send_sample(make_sample(1'b1, 950, 960));
        load_settings(make_settings(MODE_HOLD, 1000, 32'h0020_0000, 32'h0008_0000,
                                    32'h0010_0000, 32'h0004_0000, 90, 31'd50000));
        send_sample(make_sample(1'b0, 1000, 1000));
        send_sample(make_sample(1'b1, -1, -1));
        load_settings(make_settings(MODE_DRIVE, 1000, 32'h0020_0000, 32'h0008_0000,
                                    32'h0010_0000, 32'h0004_0000, 90, 31'd50000));
        send_sample(make_sample(1'b0, 960, 940));
    endtask

    // Long output hold-off while samples keep coming, so the input stalls.
    task automatic test_backpressure();
        int i;
        load_settings(make_settings(MODE_DRIVE, 2000, 32'h0010_0000, 32'h0000_4000,
                                    32'h0008_0000, 32'h0004_0000, 127, 31'd100000));
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
        hold_request   = 150;
        for (i = 0; i < 40; i++)
            send_sample(make_sample(i == 0, 1800 + 5 * i, 1790 + 5 * i));
        drain_pipeline();
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
    endtask

    // Random settings, each followed by moves toward the target with some noise.
    task automatic test_random_moves(input int items);
        int      sent;
        int      move_left;
        int      pos;
        int      goal;
        int      sign;
        int      step;
        int      noise;
        int      drift;
        int      side;
        int      pick;
        bit      restart;
        cfg_t    c;
        sample_t s;
        sent = 0;
        while (sent < items)
        begin
            c = random_settings();
            load_settings(c);
            send_gaps_on   = ($urandom_range(0, 3) != 0);
            recv_stalls_on = ($urandom_range(0, 3) != 0);
            move_left = 0;
            goal = c.target;
            sign = 1;
            pos  = 0;
            repeat ($urandom_range(60, 140))
            begin
                restart = ($urandom_range(0, 49) == 0);
                if (move_left == 0)
                begin
                    move_left = $urandom_range(10, 60);
                    pos       = clamp16(goal + $urandom_range(0, 6000) - 3000);
                    sign      = $urandom_range(0, 1) ? 1 : -1;
                    restart   = 1'b1;
                end
                move_left--;
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    s = make_sample(restart, $urandom(), $urandom());
                else
                begin
                    noise = $urandom_range(0, 20);
                    noise = noise - 10;
                    step  = (goal - pos) / int'($urandom_range(3, 12));
                    pos   = (pick == 1) ? goal : clamp16(pos + step + noise);
                    drift = $urandom_range(0, 300);
                    drift = drift - 150;
                    if (c.mode == MODE_DRIVE)
                    begin
                        side = clamp16(pos + drift);
                        s = make_sample(restart, pos, side);
                    end
                    else
                        s = make_sample(restart, clamp16(sign * pos), $urandom());
                end
                send_sample(s);
                sent++;
            end
        end
        drain_pipeline();
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        shadow_cfg.mode      = MODE_DRIVE;
        shadow_cfg.target    = TARGET_RESET;
        shadow_cfg.kp        = KP_RESET;
        shadow_cfg.ki        = KI_RESET;
        shadow_cfg.kd        = KD_RESET;
        shadow_cfg.kc        = KC_RESET;
        shadow_cfg.max_power = MAX_POWER_RESET;
        shadow_cfg.sum_limit = SUM_LIMIT_RESET;
        acc_error  = 0;
        prev_error = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_drive_mode();
        test_turn_modes();
        test_hold_mode();
        test_backpressure();
        test_random_moves(RANDOM_ITEMS);
        drain_pipeline();

        $display("Covered %0d samples and %0d checked commands over %0d register settings,",
                 samples_sent, drives_checked, settings_loaded);
        $display("in drive, turn and hold modes with random idling and a long output hold-off.");
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[pid_drive_turn_controller.f]
rtl/pdtc_pkg.sv
rtl/pdtc_error_update.sv
rtl/pid_drive_turn_controller.sv
sim/tb_pid_drive_turn_controller.sv
